// ===== hdl/bcbc_pkg.sv =====
// ---------------------------------------------------------------------------
// bcbc_pkg: shared types and tables for the block copy byte converter
// Payload structs, register indexes, result kinds and the three code ROMs.
// ---------------------------------------------------------------------------
`default_nettype none

package bcbc_pkg;

  localparam int SizeBits = 17;
  localparam int RptBits  = 32;

  typedef enum logic [2:0] {
    REG_TABLE_SELECT = 3'd0,
    REG_CASE_MODE    = 3'd1,
    REG_SWAP_PAIRS   = 3'd2,
    REG_PAD_OUTPUT   = 3'd3,
    REG_IN_BLOCK     = 3'd4,
    REG_OUT_BLOCK    = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_PAD    = 2'd1,
    KIND_REPORT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    TBL_NONE = 2'd0,
    TBL_E2A  = 2'd1,
    TBL_A2E  = 2'd2,
    TBL_A2I  = 2'd3
  } tbl_t;

  typedef enum logic [1:0] {
    CASE_KEEP  = 2'd0,
    CASE_LOWER = 2'd1,
    CASE_UPPER = 2'd2,
    CASE_RSVD  = 2'd3
  } case_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          out_byte;
    logic [SizeBits-1:0] pad_length;
    logic                in_full;
    logic                out_full;
    logic                was_truncated;
    logic [RptBits-1:0]  full_in_total;
    logic [RptBits-1:0]  partial_in_total;
    logic [RptBits-1:0]  full_out_total;
    logic [RptBits-1:0]  partial_out_total;
    logic [RptBits-1:0]  truncated_total;
    logic                last;
  } out_item_t;

  // Work entry passed from front to back: up to two bytes plus a close.
  typedef struct packed {
    logic [7:0] b0;
    logic       b0_en;
    logic [7:0] b1;
    logic       b1_en;
    logic       close;
    logic       in_full;
    logic       out_full;
    logic       trunc;
    logic       pad_en;
    logic [SizeBits-1:0] pad_len;
  } job_t;

  localparam logic [7:0] E2A [256] = '{
    8'h00,8'h01,8'h02,8'h03,8'h9C,8'h09,8'h86,8'h7F,8'h97,8'h8D,8'h8E,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,
    8'h10,8'h11,8'h12,8'h13,8'h9D,8'h85,8'h08,8'h87,8'h18,8'h19,8'h92,8'h8F,8'h1C,8'h1D,8'h1E,8'h1F,
    8'h80,8'h81,8'h82,8'h83,8'h84,8'h0A,8'h17,8'h1B,8'h88,8'h89,8'h8A,8'h8B,8'h8C,8'h05,8'h06,8'h07,
    8'h90,8'h91,8'h16,8'h93,8'h94,8'h95,8'h96,8'h04,8'h98,8'h99,8'h9A,8'h9B,8'h14,8'h15,8'h9E,8'h1A,
    8'h20,8'hA0,8'hA1,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,8'hD5,8'h2E,8'h3C,8'h28,8'h2B,8'h7C,
    8'h26,8'hA9,8'hAA,8'hAB,8'hAC,8'hAD,8'hAE,8'hAF,8'hB0,8'hB1,8'h21,8'h24,8'h2A,8'h29,8'h3B,8'h7E,
    8'h2D,8'h2F,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hCB,8'h2C,8'h25,8'h5F,8'h3E,8'h3F,
    8'hBA,8'hBB,8'hBC,8'hBD,8'hBE,8'hBF,8'hC0,8'hC1,8'hC2,8'h60,8'h3A,8'h23,8'h40,8'h27,8'h3D,8'h22,
    8'hC3,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,
    8'hCA,8'h6A,8'h6B,8'h6C,8'h6D,8'h6E,8'h6F,8'h70,8'h71,8'h72,8'h5E,8'hCC,8'hCD,8'hCE,8'hCF,8'hD0,
    8'hD1,8'hE5,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7A,8'hD2,8'hD3,8'hD4,8'h5B,8'hD6,8'hD7,
    8'hD8,8'hD9,8'hDA,8'hDB,8'hDC,8'hDD,8'hDE,8'hDF,8'hE0,8'hE1,8'hE2,8'hE3,8'hE4,8'h5D,8'hE6,8'hE7,
    8'h7B,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'hE8,8'hE9,8'hEA,8'hEB,8'hEC,8'hED,
    8'h7D,8'h4A,8'h4B,8'h4C,8'h4D,8'h4E,8'h4F,8'h50,8'h51,8'h52,8'hEE,8'hEF,8'hF0,8'hF1,8'hF2,8'hF3,
    8'h5C,8'h9F,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5A,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,
    8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'hFA,8'hFB,8'hFC,8'hFD,8'hFE,8'hFF
  };

  localparam logic [7:0] A2E [256] = '{
    8'h00,8'h01,8'h02,8'h03,8'h37,8'h2D,8'h2E,8'h2F,8'h16,8'h05,8'h25,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,
    8'h10,8'h11,8'h12,8'h13,8'h3C,8'h3D,8'h32,8'h26,8'h18,8'h19,8'h3F,8'h27,8'h1C,8'h1D,8'h1E,8'h1F,
    8'h40,8'h5A,8'h7F,8'h7B,8'h5B,8'h6C,8'h50,8'h7D,8'h4D,8'h5D,8'h5C,8'h4E,8'h6B,8'h60,8'h4B,8'h61,
    8'hF0,8'hF1,8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'h7A,8'h5E,8'h4C,8'h7E,8'h6E,8'h6F,
    8'h7C,8'hC1,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hD1,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,
    8'hD7,8'hD8,8'hD9,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hAD,8'hE0,8'hBD,8'h9A,8'h6D,
    8'h79,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,
    8'h97,8'h98,8'h99,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,8'hA9,8'hC0,8'h4F,8'hD0,8'h5F,8'h07,
    8'h20,8'h21,8'h22,8'h23,8'h24,8'h15,8'h06,8'h17,8'h28,8'h29,8'h2A,8'h2B,8'h2C,8'h09,8'h0A,8'h1B,
    8'h30,8'h31,8'h1A,8'h33,8'h34,8'h35,8'h36,8'h08,8'h38,8'h39,8'h3A,8'h3B,8'h04,8'h14,8'h3E,8'hE1,
    8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,
    8'h76,8'h77,8'h78,8'h80,8'h8A,8'h8B,8'h8C,8'h8D,8'h8E,8'h8F,8'h90,8'h6A,8'h9B,8'h9C,8'h9D,8'h9E,
    8'h9F,8'hA0,8'hAA,8'hAB,8'hAC,8'h4A,8'hAE,8'hAF,8'hB0,8'hB1,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,
    8'hB8,8'hB9,8'hBA,8'hBB,8'hBC,8'hA1,8'hBE,8'hBF,8'hCA,8'hCB,8'hCC,8'hCD,8'hCE,8'hCF,8'hDA,8'hDB,
    8'hDC,8'hDD,8'hDE,8'hDF,8'hEA,8'hEB,8'hEC,8'hED,8'hEE,8'hEF,8'hFA,8'hFB,8'hFC,8'hFD,8'hFE,8'hFF
  };

  localparam logic [7:0] A2I [256] = '{
    8'h00,8'h01,8'h02,8'h03,8'h37,8'h2D,8'h2E,8'h2F,8'h16,8'h05,8'h25,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,
    8'h10,8'h11,8'h12,8'h13,8'h3C,8'h3D,8'h32,8'h26,8'h18,8'h19,8'h3F,8'h27,8'h1C,8'h1D,8'h1E,8'h1F,
    8'h40,8'h5A,8'h7F,8'h7B,8'h5B,8'h6C,8'h50,8'h7D,8'h4D,8'h5D,8'h5C,8'h4E,8'h6B,8'h60,8'h4B,8'h61,
    8'hF0,8'hF1,8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'h7A,8'h5E,8'h4C,8'h7E,8'h6E,8'h6F,
    8'h7C,8'hC1,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hD1,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,
    8'hD7,8'hD8,8'hD9,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hAD,8'hE0,8'hBD,8'h5F,8'h6D,
    8'h79,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,
    8'h97,8'h98,8'h99,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,8'hA9,8'hC0,8'h4F,8'hD0,8'hA1,8'h07,
    8'h20,8'h21,8'h22,8'h23,8'h24,8'h15,8'h06,8'h17,8'h28,8'h29,8'h2A,8'h2B,8'h2C,8'h09,8'h0A,8'h1B,
    8'h30,8'h31,8'h1A,8'h33,8'h34,8'h35,8'h36,8'h08,8'h38,8'h39,8'h3A,8'h3B,8'h04,8'h14,8'h3E,8'hE1,
    8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,
    8'h76,8'h77,8'h78,8'h80,8'h8A,8'h8B,8'h8C,8'h8D,8'h8E,8'h8F,8'h90,8'h9A,8'h9B,8'h9C,8'h9D,8'h9E,
    8'h9F,8'hA0,8'hAA,8'hAB,8'hAC,8'hAD,8'hAE,8'hAF,8'hB0,8'hB1,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,
    8'hB8,8'hB9,8'hBA,8'hBB,8'hBC,8'hBD,8'hBE,8'hBF,8'hCA,8'hCB,8'hCC,8'hCD,8'hCE,8'hCF,8'hDA,8'hDB,
    8'hDC,8'hDD,8'hDE,8'hDF,8'hEA,8'hEB,8'hEC,8'hED,8'hEE,8'hEF,8'hFA,8'hFB,8'hFC,8'hFD,8'hFE,8'hFF
  };

endpackage

`default_nettype wire

// ===== hdl/block_copy_byte_converter.sv =====
// ---------------------------------------------------------------------------
// block_copy_byte_converter: record byte converter with case fold and swap
// Front folds and pairs bytes, a work queue decouples it from the back,
// which converts and emits bytes, pad runs and record reports.
// ---------------------------------------------------------------------------
//   channel  direction  handshake        payload
//   in_      input      valid / stall    bcbc_pkg::in_item_t
//   out_     output     valid / stall    bcbc_pkg::out_item_t
//   cfg_     input      write enable     index 3 bits, data 17 bits
// One byte is accepted per cycle while the queue has room; the back side
// sends one result per cycle unless the output stalls, and offers the first
// result of an item from its result register once the job is at the queue
// head. An item makes up to four results (a swapped pair, pad run and report),
// so closes in quick succession fill the four-entry queue and stall the input.
// Reset is synchronous: registers, position and counters clear at once.
// An output stall holds the result register and backs up through the queue.
`default_nettype none

module block_copy_byte_converter #(
  parameter int BLOCK_LIMIT  = 65536,
  parameter int COUNTER_BITS = 32
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire bcbc_pkg::in_item_t    in_item,
  output logic                       out_valid,
  input  wire                        out_stall,
  output bcbc_pkg::out_item_t        out_item,
  input  wire                        cfg_we,
  input  wire [2:0]                  cfg_index,
  input  wire [bcbc_pkg::SizeBits-1:0] cfg_data
);

  bcbc_pkg::tbl_t  tsel_r;
  bcbc_pkg::case_t cmode_r;
  logic            swap_r, pad_r;
  logic [bcbc_pkg::SizeBits-1:0] ibs_r, obs_r;

  bcbc_pkg::job_t job, head;
  logic job_valid, not_full, not_empty, pop, take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsel_r  <= bcbc_pkg::TBL_NONE;
      cmode_r <= bcbc_pkg::CASE_KEEP;
      swap_r  <= 1'b0;
      pad_r   <= 1'b0;
      ibs_r   <= bcbc_pkg::SizeBits'(512);
      obs_r   <= bcbc_pkg::SizeBits'(512);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcbc_pkg::REG_TABLE_SELECT: tsel_r  <= bcbc_pkg::tbl_t'(cfg_data[1:0]);
        bcbc_pkg::REG_CASE_MODE:    cmode_r <= bcbc_pkg::case_t'(cfg_data[1:0]);
        bcbc_pkg::REG_SWAP_PAIRS:   swap_r  <= cfg_data[0];
        bcbc_pkg::REG_PAD_OUTPUT:   pad_r   <= cfg_data[0];
        bcbc_pkg::REG_IN_BLOCK:     ibs_r   <= cfg_data;
        bcbc_pkg::REG_OUT_BLOCK:    obs_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !not_full;
  assign take     = in_valid && not_full;

  bcbc_front #(.BLOCK_LIMIT(BLOCK_LIMIT)) u_front (
    .clk, .rst_n, .take, .item(in_item),
    .table_select(tsel_r), .case_mode(cmode_r), .swap_pairs(swap_r),
    .pad_output(pad_r), .in_block_size(ibs_r), .out_block_size(obs_r),
    .job, .job_valid
  );

  bcbc_queue u_queue (
    .clk, .rst_n, .push(take && job_valid), .push_data(job), .pop,
    .head, .not_empty, .not_full
  );

  bcbc_back #(.COUNTER_BITS(COUNTER_BITS)) u_back (
    .clk, .rst_n, .head, .head_valid(not_empty), .pop,
    .table_select(tsel_r), .out_valid, .out_stall, .out_item
  );

`ifndef SYNTH
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> not_empty) else $error("stall with empty queue");
  a_out_from_job: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(not_empty)) else $error("result without job");
  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> $stable(ibs_r) && $stable(obs_r)) else $error("size moved");
`endif

endmodule

`default_nettype wire

// ===== hdl/bcbc_front.sv =====
// ---------------------------------------------------------------------------
// bcbc_front: input side of the block copy byte converter
// Folds each byte, tracks the record position, pairs bytes for the swap and
// works out the close flags and pad run of a record.
// ---------------------------------------------------------------------------
`default_nettype none

module bcbc_front #(
  parameter int BLOCK_LIMIT = 65536
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         take,
  input  wire bcbc_pkg::in_item_t     item,
  input  wire bcbc_pkg::tbl_t         table_select,
  input  wire bcbc_pkg::case_t        case_mode,
  input  wire                         swap_pairs,
  input  wire                         pad_output,
  input  wire [bcbc_pkg::SizeBits-1:0] in_block_size,
  input  wire [bcbc_pkg::SizeBits-1:0] out_block_size,
  output bcbc_pkg::job_t              job,
  output logic                        job_valid
);

  localparam int PW = $clog2(BLOCK_LIMIT + 1);
  localparam int SW = (PW > bcbc_pkg::SizeBits) ? PW : bcbc_pkg::SizeBits;
  localparam logic [SW-1:0] Lim = SW'(BLOCK_LIMIT);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    held_r, held_nxt;
  logic          held_v_r, held_v_nxt;

  logic [7:0]    b_tab, b;
  logic [SW-1:0] ibs, obs, p, len, p_lo, kept, written;
  logic          closes, in_full;

  function automatic logic [SW-1:0] eff(input logic [bcbc_pkg::SizeBits-1:0] v);
    logic [SW-1:0] w;
    w = SW'(v);
    if (v == '0) return SW'(1);
    if (w > Lim) return Lim;
    return w;
  endfunction

  always_comb begin
    b_tab = (table_select == bcbc_pkg::TBL_E2A) ? bcbc_pkg::E2A[item.data_byte]
                                                : item.data_byte;
    b = b_tab;
    if (case_mode == bcbc_pkg::CASE_LOWER && b_tab >= 8'h41 && b_tab <= 8'h5A)
      b = b_tab + 8'h20;
    if (case_mode == bcbc_pkg::CASE_UPPER && b_tab >= 8'h61 && b_tab <= 8'h7A)
      b = b_tab - 8'h20;

    ibs     = eff(in_block_size);
    obs     = eff(out_block_size);
    p       = SW'(pos_r);
    len     = p + SW'(1);
    p_lo    = (p == '0) ? '0 : p - SW'(1);
    closes  = item.end_of_stream || (len >= ibs);
    in_full = len >= ibs;
    kept    = (len < obs) ? len : obs;
    written = (in_full || pad_output) ? obs : kept;

    job = '0;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    if (held_v_r) begin
      job.b0 = b;
      job.b0_en = p_lo < obs;
      job.b1 = held_r;
      job.b1_en = p < obs;
      held_v_nxt = 1'b0;
    end else if (swap_pairs && !pos_r[0] && !closes) begin
      held_nxt   = b;
      held_v_nxt = 1'b1;
    end else begin
      job.b0 = b;
      job.b0_en = p < obs;
    end
    job.close    = closes;
    job.in_full  = in_full;
    job.out_full = written >= obs;
    job.trunc    = len > obs;
    job.pad_en   = written > kept;
    job.pad_len  = bcbc_pkg::SizeBits'(written - kept);
    job_valid    = job.b0_en || job.b1_en || closes;

    pos_nxt = closes ? '0 : PW'(len);
    if (closes) held_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      held_v_r <= 1'b0;
      held_r   <= '0;
    end else if (take) begin
      pos_r    <= pos_nxt;
      held_v_r <= held_v_nxt;
      held_r   <= held_nxt;
    end
  end

`ifndef SYNTH
  a_hold_even: assert property (@(posedge clk) disable iff (!rst_n)
    held_v_r |-> pos_r[0]) else $error("held byte at even position");
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && closes |=> pos_r == '0 && !held_v_r) else $error("close left state");
  a_pair_out: assert property (@(posedge clk) disable iff (!rst_n)
    take && held_v_r |=> !held_v_r) else $error("held byte not released");
`endif

endmodule

`default_nettype wire

// ===== hdl/bcbc_queue.sv =====
// ---------------------------------------------------------------------------
// bcbc_queue: small work queue between front and back
// Four-entry register queue; a push and a pop may share a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module bcbc_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  wire bcbc_pkg::job_t   push_data,
  input  wire                   pop,
  output bcbc_pkg::job_t        head,
  output logic                  not_empty,
  output logic                  not_full
);

  localparam int Depth = 4;

  bcbc_pkg::job_t mem_r [Depth];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign head      = mem_r[rp_r];
  assign not_empty = cnt_r != '0;
  assign not_full  = cnt_r != 3'(Depth);

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end

`ifndef SYNTH
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full || pop) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(Depth)) else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== hdl/bcbc_back.sv =====
// ---------------------------------------------------------------------------
// bcbc_back: output side of the block copy byte converter
// Sends the bytes of a queued job through the output ROM, then the pad run
// and record report, one result a cycle unless stalled, and keeps the counters.
// ---------------------------------------------------------------------------
`default_nettype none

module bcbc_back #(
  parameter int COUNTER_BITS = 32
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire bcbc_pkg::job_t     head,
  input  wire                     head_valid,
  output logic                    pop,
  input  wire bcbc_pkg::tbl_t     table_select,
  output logic                    out_valid,
  input  wire                     out_stall,
  output bcbc_pkg::out_item_t     out_item
);

  localparam int CW = COUNTER_BITS;
  localparam logic [CW-1:0] Top = '1;

  // step: 0 first byte, 1 second byte, 2 pad, 3 report
  logic [1:0] step_r, step_nxt;
  logic       ov_r;
  bcbc_pkg::out_item_t ob_r;
  logic [CW-1:0] fi_r, pi_r, fo_r, po_r, tr_r;

  logic       sel_v, sel_last, load;
  logic [1:0] sel_step;
  bcbc_pkg::out_item_t r;
  logic [7:0] byte_sel, byte_cv;
  logic [CW-1:0] fi_n, pi_n, fo_n, po_n, tr_n;

  function automatic logic [CW-1:0] sat(input logic [CW-1:0] c);
    return (c == Top) ? c : c + CW'(1);
  endfunction

  // find the next pending result of the head job at or after step_r
  always_comb begin
    sel_v = 1'b0;
    sel_step = step_r;
    priority if (step_r == 2'd0 && head.b0_en) begin
      sel_v = 1'b1; sel_step = 2'd0;
    end else if (step_r <= 2'd1 && head.b1_en) begin
      sel_v = 1'b1; sel_step = 2'd1;
    end else if (step_r <= 2'd2 && head.close && head.pad_en) begin
      sel_v = 1'b1; sel_step = 2'd2;
    end else if (head.close) begin
      sel_v = 1'b1; sel_step = 2'd3;
    end else begin
      sel_v = 1'b0;
    end
    sel_v = sel_v && head_valid;

    unique case (sel_step)
      2'd0:    sel_last = !head.b1_en && !head.close;
      2'd1:    sel_last = !head.close;
      2'd2:    sel_last = 1'b0;
      default: sel_last = 1'b1;
    endcase

    byte_sel = (sel_step == 2'd0) ? head.b0 : head.b1;
    unique case (table_select)
      bcbc_pkg::TBL_A2E: byte_cv = bcbc_pkg::A2E[byte_sel];
      bcbc_pkg::TBL_A2I: byte_cv = bcbc_pkg::A2I[byte_sel];
      default:           byte_cv = byte_sel;
    endcase

    fi_n = head.in_full  ? sat(fi_r) : fi_r;
    pi_n = head.in_full  ? pi_r : sat(pi_r);
    fo_n = head.out_full ? sat(fo_r) : fo_r;
    po_n = head.out_full ? po_r : sat(po_r);
    tr_n = head.trunc    ? sat(tr_r) : tr_r;

    r = '0;
    r.last = sel_last;
    unique case (sel_step)
      2'd0, 2'd1: begin
        r.kind = bcbc_pkg::KIND_BYTE;
        r.out_byte = byte_cv;
      end
      2'd2: begin
        r.kind = bcbc_pkg::KIND_PAD;
        r.pad_length = head.pad_len;
      end
      default: begin
        r.kind = bcbc_pkg::KIND_REPORT;
        r.in_full = head.in_full;
        r.out_full = head.out_full;
        r.was_truncated = head.trunc;
        r.full_in_total = bcbc_pkg::RptBits'(fi_n);
        r.partial_in_total = bcbc_pkg::RptBits'(pi_n);
        r.full_out_total = bcbc_pkg::RptBits'(fo_n);
        r.partial_out_total = bcbc_pkg::RptBits'(po_n);
        r.truncated_total = bcbc_pkg::RptBits'(tr_n);
      end
    endcase

    load = sel_v && (!ov_r || !out_stall);
    pop  = load && sel_last;
    step_nxt = step_r;
    if (load) step_nxt = sel_last ? 2'd0 : sel_step + 2'd1;
  end

  assign out_valid = ov_r;
  assign out_item  = ob_r;

  always_ff @(posedge clk) begin
    if (load) ob_r <= r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      step_r <= '0;
      fi_r <= '0; pi_r <= '0; fo_r <= '0; po_r <= '0; tr_r <= '0;
    end else begin
      step_r <= step_nxt;
      if (load) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      if (load && sel_step == 2'd3) begin
        fi_r <= fi_n; pi_r <= pi_n; fo_r <= fo_n; po_r <= po_n; tr_r <= tr_n;
      end
    end
  end

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r && $stable(ob_r)) else $error("result lost");
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> r.last) else $error("job popped before last");
  a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> step_r == 2'd0) else $error("step without job");
`endif

endmodule

`default_nettype wire
